// ===== rtl/bhpq_pkg.sv =====
// Shared constants, types and controller/datapath interface for the heap queue.
`default_nettype none

package bhpq_pkg;

   // Heap capacity in entries (2 to 4096).
   localparam int HEAP_DEPTH = 64;

   // Key width fixed by the request format.
   localparam int KEY_W = 32;

   // Entry count holds 0..HEAP_DEPTH.
   localparam int CNT_W = $clog2(HEAP_DEPTH + 1);

   // Heap positions and scan index hold 1..HEAP_DEPTH+1.
   localparam int IDX_W = $clog2(HEAP_DEPTH + 2);

   // Child positions reach 2*HEAP_DEPTH+1.
   localparam int CHILD_W = IDX_W + 1;

   // Memory address (position minus one).
   localparam int ADDR_W = $clog2(HEAP_DEPTH);

   // Request commands.
   typedef enum logic [1:0] {
      CMD_INSERT   = 2'd0,
      CMD_REMOVE   = 2'd1,
      CMD_INCREASE = 2'd2
   } cmd_type;

   // Response status codes.
   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_EMPTY = 2'd2
   } status_type;

   // Controller states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_UP_RD,
      ST_UP_CMP,
      ST_RM_TAKE,
      ST_RM_CHECK,
      ST_DN_RD,
      ST_DN_CMP,
      ST_SC_RD,
      ST_SC_CMP,
      ST_RESP
   } state_type;

   // Datapath commands from the controller.
   typedef struct packed {
      logic load;       // latch the request
      logic ins_begin;  // append: grow count, hole at new last position
      logic up_rd;      // read parent of the hole
      logic up_step;    // move parent down into the hole, hole climbs
      logic hole_wr;    // write the hole key at the hole position
      logic rm_rd;      // read last entry
      logic rm_begin;   // last entry becomes hole key at root, shrink count
      logic dn_rd;      // read both children of the hole
      logic dn_step;    // move larger child up, hole descends
      logic scan_init;  // scan index to first position
      logic scan_rd;    // read entry at scan index
      logic scan_hit;   // start sift-up of new key at scan index
      logic scan_next;  // advance scan index
      logic set_full;   // status: insert refused
      logic set_empty;  // status: remove on empty
   } dp_cmd_type;

   // Datapath status to the controller.
   typedef struct packed {
      cmd_type op;          // latched command code
      logic    full;        // count at capacity
      logic    empty;       // count is zero
      logic    pos_root;    // hole is at the root
      logic    up_swap;     // parent is smaller than the hole key
      logic    dn_move;     // a child is larger than the hole key
      logic    key_bad;     // new key below old key
      logic    scan_end;    // scan index past last entry
      logic    scan_match;  // scanned entry equals old key
   } dp_stat_type;

endpackage

`default_nettype wire

// ===== rtl/bhpq_dpath.sv =====
// Heap datapath: key memory, count, hole register, compare logic and response fields.
`default_nettype none

module bhpq_dpath (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire  bhpq_pkg::dp_cmd_type           cmd,
   output bhpq_pkg::dp_stat_type                stat,
   input  wire  [1:0]                           req_cmd,
   input  wire  signed [bhpq_pkg::KEY_W-1:0]    req_key_value,
   input  wire  signed [bhpq_pkg::KEY_W-1:0]    req_new_key,
   output logic signed [bhpq_pkg::KEY_W-1:0]    rsp_top_key,
   output logic                                 rsp_top_valid,
   output logic [bhpq_pkg::CNT_W-1:0]           rsp_entry_total,
   output logic [1:0]                           rsp_status
);

   // Key store, position p lives at address p-1
   logic signed [bhpq_pkg::KEY_W-1:0] mem [bhpq_pkg::HEAP_DEPTH];

   // Registers
   bhpq_pkg::cmd_type                   op_ff, op_in;
   logic signed [bhpq_pkg::KEY_W-1:0]   key_ff, key_in;
   logic signed [bhpq_pkg::KEY_W-1:0]   nkey_ff, nkey_in;
   logic [bhpq_pkg::CNT_W-1:0]          count_ff, count_in;
   logic [bhpq_pkg::IDX_W-1:0]          pos_ff, pos_in;
   logic [bhpq_pkg::IDX_W-1:0]          idx_ff, idx_in;
   logic signed [bhpq_pkg::KEY_W-1:0]   hole_ff, hole_in;
   logic signed [bhpq_pkg::KEY_W-1:0]   root_ff;
   bhpq_pkg::status_type                status_ff, status_in;
   logic signed [bhpq_pkg::KEY_W-1:0]   rd_a_ff;
   logic signed [bhpq_pkg::KEY_W-1:0]   rd_b_ff;

   // Child positions and sift-down choice
   logic [bhpq_pkg::CHILD_W-1:0]        lchild;
   logic [bhpq_pkg::CHILD_W-1:0]        rchild;
   logic [bhpq_pkg::CHILD_W-1:0]        count_c;
   logic                                left_ok;
   logic                                right_ok;
   logic                                take_l;
   logic                                take_r;
   logic signed [bhpq_pkg::KEY_W-1:0]   best_l;
   logic signed [bhpq_pkg::KEY_W-1:0]   best_val;
   logic [bhpq_pkg::CHILD_W-1:0]        best_pos;

   // Memory port signals
   logic                                rd_en;
   logic [bhpq_pkg::CHILD_W-1:0]        rd_a_pos;
   logic [bhpq_pkg::CHILD_W-1:0]        rd_a_off;
   logic [bhpq_pkg::ADDR_W-1:0]         rd_a_addr;
   logic [bhpq_pkg::ADDR_W-1:0]         rd_b_addr;
   logic                                wr_en;
   logic signed [bhpq_pkg::KEY_W-1:0]   wr_data;
   logic [bhpq_pkg::IDX_W-1:0]          wr_off;
   logic [bhpq_pkg::ADDR_W-1:0]         wr_addr;

   // Sift-down: pick larger child, left first, right only if strictly larger
   always_comb begin
      lchild   = {pos_ff, 1'b0};
      rchild   = lchild | bhpq_pkg::CHILD_W'(1);
      count_c  = bhpq_pkg::CHILD_W'(count_ff);
      left_ok  = lchild <= count_c;
      right_ok = rchild <= count_c;
      take_l   = left_ok && (hole_ff < rd_a_ff);
      best_l   = take_l ? rd_a_ff : hole_ff;
      take_r   = right_ok && (best_l < rd_b_ff);
      best_val = take_r ? rd_b_ff : rd_a_ff;
      best_pos = take_r ? rchild : lchild;
   end

   // Read address selection
   always_comb begin
      rd_en = cmd.up_rd | cmd.rm_rd | cmd.scan_rd | cmd.dn_rd;
      priority if (cmd.up_rd) begin
         rd_a_pos = bhpq_pkg::CHILD_W'(pos_ff >> 1);
      end else if (cmd.rm_rd) begin
         rd_a_pos = bhpq_pkg::CHILD_W'(count_ff);
      end else if (cmd.scan_rd) begin
         rd_a_pos = bhpq_pkg::CHILD_W'(idx_ff);
      end else begin
         rd_a_pos = lchild;
      end
      rd_a_off  = rd_a_pos - bhpq_pkg::CHILD_W'(1);
      rd_a_addr = rd_a_off[bhpq_pkg::ADDR_W-1:0];
      // right child 2p+1 sits at address 2p
      rd_b_addr = lchild[bhpq_pkg::ADDR_W-1:0];
   end

   // Write port: always at the hole position
   always_comb begin
      wr_en   = cmd.hole_wr | cmd.up_step | cmd.dn_step;
      wr_off  = pos_ff - bhpq_pkg::IDX_W'(1);
      wr_addr = wr_off[bhpq_pkg::ADDR_W-1:0];
      priority if (cmd.up_step) begin
         wr_data = rd_a_ff;
      end else if (cmd.dn_step) begin
         wr_data = best_val;
      end else begin
         wr_data = hole_ff;
      end
   end

   // Memory
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= mem[rd_a_addr];
         rd_b_ff <= mem[rd_b_addr];
      end
   end

   // Next-state of working registers
   always_comb begin
      op_in     = op_ff;
      key_in    = key_ff;
      nkey_in   = nkey_ff;
      count_in  = count_ff;
      pos_in    = pos_ff;
      idx_in    = idx_ff;
      hole_in   = hole_ff;
      status_in = status_ff;
      if (cmd.load) begin
         op_in     = bhpq_pkg::cmd_type'(req_cmd);
         key_in    = req_key_value;
         nkey_in   = req_new_key;
         status_in = bhpq_pkg::STAT_OK;
      end
      if (cmd.ins_begin) begin
         count_in = count_ff + bhpq_pkg::CNT_W'(1);
         pos_in   = bhpq_pkg::IDX_W'(count_ff) + bhpq_pkg::IDX_W'(1);
         hole_in  = key_ff;
      end
      if (cmd.up_step) begin
         pos_in = pos_ff >> 1;
      end
      if (cmd.rm_begin) begin
         hole_in  = rd_a_ff;
         count_in = count_ff - bhpq_pkg::CNT_W'(1);
         pos_in   = bhpq_pkg::IDX_W'(1);
      end
      if (cmd.dn_step) begin
         pos_in = best_pos[bhpq_pkg::IDX_W-1:0];
      end
      if (cmd.scan_init) begin
         idx_in = bhpq_pkg::IDX_W'(1);
      end
      if (cmd.scan_hit) begin
         hole_in = nkey_ff;
         pos_in  = idx_ff;
      end
      if (cmd.scan_next) begin
         idx_in = idx_ff + bhpq_pkg::IDX_W'(1);
      end
      if (cmd.set_full) begin
         status_in = bhpq_pkg::STAT_FULL;
      end
      if (cmd.set_empty) begin
         status_in = bhpq_pkg::STAT_EMPTY;
      end
   end

   // Registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      op_ff     <= op_in;
      key_ff    <= key_in;
      nkey_ff   <= nkey_in;
      pos_ff    <= pos_in;
      idx_ff    <= idx_in;
      hole_ff   <= hole_in;
      status_ff <= status_in;
      // shadow copy of the root entry
      if (wr_en && (pos_ff == bhpq_pkg::IDX_W'(1))) begin
         root_ff <= wr_data;
      end
   end

   // Status to controller
   always_comb begin
      stat.op         = op_ff;
      stat.full       = count_ff == bhpq_pkg::CNT_W'(bhpq_pkg::HEAP_DEPTH);
      stat.empty      = count_ff == '0;
      stat.pos_root   = pos_ff == bhpq_pkg::IDX_W'(1);
      stat.up_swap    = rd_a_ff < hole_ff;
      stat.dn_move    = take_l | take_r;
      stat.key_bad    = nkey_ff < key_ff;
      stat.scan_end   = idx_ff > bhpq_pkg::IDX_W'(count_ff);
      stat.scan_match = rd_a_ff == key_ff;
   end

   // Response fields
   assign rsp_top_valid   = count_ff != '0;
   assign rsp_top_key     = rsp_top_valid ? root_ff : '0;
   assign rsp_entry_total = count_ff;
   assign rsp_status      = status_ff;

   // Count never exceeds capacity
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= bhpq_pkg::CNT_W'(bhpq_pkg::HEAP_DEPTH))
      else $error("entry count above capacity");

   // An append grows the count by exactly one
   assert property (@(posedge clock) disable iff (reset)
      cmd.ins_begin |=> count_ff == $past(count_ff) + bhpq_pkg::CNT_W'(1))
      else $error("insert did not grow count by one");

   // Sift-down only from a live position
   assert property (@(posedge clock) disable iff (reset)
      cmd.dn_rd |-> (pos_ff != '0) && (pos_ff <= bhpq_pkg::IDX_W'(count_ff)))
      else $error("sift-down position outside heap");

endmodule

`default_nettype wire

// ===== rtl/bhpq_ctrl.sv =====
// Heap controller: state machine sequencing insert, remove and increase-key.
`default_nettype none

module bhpq_ctrl (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     start,
   input  wire bhpq_pkg::dp_stat_type stat,
   output bhpq_pkg::dp_cmd_type    cmd,
   output logic                    busy,
   output logic                    rsp_strobe
);

   bhpq_pkg::state_type state_ff, state_in;
   logic                in_scan_ff, in_scan_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= bhpq_pkg::ST_IDLE;
         in_scan_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         in_scan_ff <= in_scan_in;
      end
   end

   // Next state and datapath commands
   always_comb begin
      state_in   = state_ff;
      in_scan_in = in_scan_ff;
      cmd        = '0;
      busy       = 1'b1;
      rsp_strobe = 1'b0;
      unique case (state_ff)
         bhpq_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = bhpq_pkg::ST_DECODE;
            end
         end
         bhpq_pkg::ST_DECODE: begin
            unique case (stat.op)
               bhpq_pkg::CMD_INSERT: begin
                  if (stat.full) begin
                     cmd.set_full = 1'b1;
                     state_in     = bhpq_pkg::ST_RESP;
                  end else begin
                     cmd.ins_begin = 1'b1;
                     state_in      = bhpq_pkg::ST_UP_RD;
                  end
               end
               bhpq_pkg::CMD_REMOVE: begin
                  if (stat.empty) begin
                     cmd.set_empty = 1'b1;
                     state_in      = bhpq_pkg::ST_RESP;
                  end else begin
                     cmd.rm_rd = 1'b1;
                     state_in  = bhpq_pkg::ST_RM_TAKE;
                  end
               end
               bhpq_pkg::CMD_INCREASE: begin
                  if (stat.key_bad) begin
                     state_in = bhpq_pkg::ST_RESP;
                  end else begin
                     cmd.scan_init = 1'b1;
                     in_scan_in    = 1'b1;
                     state_in      = bhpq_pkg::ST_SC_RD;
                  end
               end
               default: begin
                  state_in = bhpq_pkg::ST_RESP;
               end
            endcase
         end
         // sift-up: hole climbs while parent is smaller
         bhpq_pkg::ST_UP_RD: begin
            if (stat.pos_root) begin
               cmd.hole_wr = 1'b1;
               if (in_scan_ff) begin
                  cmd.scan_next = 1'b1;
                  state_in      = bhpq_pkg::ST_SC_RD;
               end else begin
                  state_in = bhpq_pkg::ST_RESP;
               end
            end else begin
               cmd.up_rd = 1'b1;
               state_in  = bhpq_pkg::ST_UP_CMP;
            end
         end
         bhpq_pkg::ST_UP_CMP: begin
            if (stat.up_swap) begin
               cmd.up_step = 1'b1;
               state_in    = bhpq_pkg::ST_UP_RD;
            end else begin
               cmd.hole_wr = 1'b1;
               if (in_scan_ff) begin
                  cmd.scan_next = 1'b1;
                  state_in      = bhpq_pkg::ST_SC_RD;
               end else begin
                  state_in = bhpq_pkg::ST_RESP;
               end
            end
         end
         // remove: last entry becomes the hole key at the root
         bhpq_pkg::ST_RM_TAKE: begin
            cmd.rm_begin = 1'b1;
            state_in     = bhpq_pkg::ST_RM_CHECK;
         end
         bhpq_pkg::ST_RM_CHECK: begin
            state_in = stat.empty ? bhpq_pkg::ST_RESP : bhpq_pkg::ST_DN_RD;
         end
         // sift-down: hole descends while a child is larger
         bhpq_pkg::ST_DN_RD: begin
            cmd.dn_rd = 1'b1;
            state_in  = bhpq_pkg::ST_DN_CMP;
         end
         bhpq_pkg::ST_DN_CMP: begin
            if (stat.dn_move) begin
               cmd.dn_step = 1'b1;
               state_in    = bhpq_pkg::ST_DN_RD;
            end else begin
               cmd.hole_wr = 1'b1;
               state_in    = bhpq_pkg::ST_RESP;
            end
         end
         // increase-key scan over all live positions
         bhpq_pkg::ST_SC_RD: begin
            if (stat.scan_end) begin
               in_scan_in = 1'b0;
               state_in   = bhpq_pkg::ST_RESP;
            end else begin
               cmd.scan_rd = 1'b1;
               state_in    = bhpq_pkg::ST_SC_CMP;
            end
         end
         bhpq_pkg::ST_SC_CMP: begin
            if (stat.scan_match) begin
               cmd.scan_hit = 1'b1;
               state_in     = bhpq_pkg::ST_UP_RD;
            end else begin
               cmd.scan_next = 1'b1;
               state_in      = bhpq_pkg::ST_SC_RD;
            end
         end
         bhpq_pkg::ST_RESP: begin
            rsp_strobe = 1'b1;
            state_in   = bhpq_pkg::ST_IDLE;
         end
         default: begin
            state_in = bhpq_pkg::ST_IDLE;
         end
      endcase
   end

   // Response strobe lasts one cycle
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("response strobe longer than one cycle");

   // A request is only taken when idle, and the next cycle is busy
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy && !rsp_strobe)
      else $error("request not followed by busy");

   // Scan mode only lives inside an increase-key
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == bhpq_pkg::ST_IDLE) |-> !in_scan_ff)
      else $error("scan flag left set at idle");

endmodule

`default_nettype wire

// ===== rtl/binary_heap_max_priority_queue_top.sv =====
// Top level of the binary max-heap priority queue.
`default_nettype none

// Max-heap of signed 32-bit keys, up to HEAP_DEPTH entries. A request is taken
// when start is high and busy is low; one response follows with rsp_strobe high
// for one cycle and cannot be held off. Every step of a sift is a registered
// key-memory read followed by a compare that moves a key through the single
// write port. Insert climbs from the new last position and is refused when the
// heap is full; remove descends from the root and reports an empty heap;
// increase-key scans every entry and climbs from each matching one. An increase
// with the new key below the old one and the unused command code go straight to
// the response. Busy stays high through the response cycle, so the next request
// is taken in the cycle after the response at the earliest. With 64 entries a
// sift spans at most 6 levels. The key memory needs no clearing after reset.
module binary_heap_max_priority_queue_top (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  start,
   output logic                                 busy,
   input  wire  [1:0]                           req_cmd,
   input  wire  signed [bhpq_pkg::KEY_W-1:0]    req_key_value,
   input  wire  signed [bhpq_pkg::KEY_W-1:0]    req_new_key,
   output logic                                 rsp_strobe,
   output logic signed [bhpq_pkg::KEY_W-1:0]    rsp_top_key,
   output logic                                 rsp_top_valid,
   output logic [bhpq_pkg::CNT_W-1:0]           rsp_entry_total,
   output logic [1:0]                           rsp_status
);

   bhpq_pkg::dp_cmd_type  dp_cmd;
   bhpq_pkg::dp_stat_type dp_stat;

   // Sequencer
   bhpq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .stat       (dp_stat),
      .cmd        (dp_cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   // Key memory and compare logic
   bhpq_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (dp_cmd),
      .stat            (dp_stat),
      .req_cmd         (req_cmd),
      .req_key_value   (req_key_value),
      .req_new_key     (req_new_key),
      .rsp_top_key     (rsp_top_key),
      .rsp_top_valid   (rsp_top_valid),
      .rsp_entry_total (rsp_entry_total),
      .rsp_status      (rsp_status)
   );

endmodule

`default_nettype wire

// ===== tb/sv/heap_queue_checker.sv =====
// Response checker for the heap queue: keeps its own max-heap and compares every response.
`timescale 1ns / 100ps

module heap_queue_checker (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                start,
   input  wire                                busy,
   input  wire  [1:0]                         req_cmd,
   input  wire  signed [bhpq_pkg::KEY_W-1:0]  req_key_value,
   input  wire  signed [bhpq_pkg::KEY_W-1:0]  req_new_key,
   input  wire                                rsp_strobe,
   input  wire  signed [bhpq_pkg::KEY_W-1:0]  rsp_top_key,
   input  wire                                rsp_top_valid,
   input  wire  [bhpq_pkg::CNT_W-1:0]         rsp_entry_total,
   input  wire  [1:0]                         rsp_status,
   output int                                 mismatch_count,
   output int                                 pending_count
);

   // What one response should carry.
   typedef struct {
      logic signed [bhpq_pkg::KEY_W-1:0] top_key;
      logic                              top_valid;
      logic [bhpq_pkg::CNT_W-1:0]        entry_total;
      bhpq_pkg::status_type              status;
   } heap_view_type;

   // Mirror of the heap, positions 1..heap_size.
   logic signed [bhpq_pkg::KEY_W-1:0] heap_keys [1:bhpq_pkg::HEAP_DEPTH];
   int                                heap_size;

   heap_view_type                     expected_views [$];

   // Climb while the parent is strictly smaller.
   function automatic void sift_toward_root(input int pos);
      logic signed [bhpq_pkg::KEY_W-1:0] held;
      while (pos > 1 && heap_keys[pos / 2] < heap_keys[pos]) begin
         held                = heap_keys[pos / 2];
         heap_keys[pos / 2]  = heap_keys[pos];
         heap_keys[pos]      = held;
         pos                 = pos / 2;
      end
   endfunction

   // Descend toward the larger child; left wins ties with the right.
   function automatic void sift_toward_leaves(input int pos);
      int                                best;
      logic signed [bhpq_pkg::KEY_W-1:0] held;
      while (pos >= 1 && pos <= heap_size) begin
         best = pos;
         if (2 * pos <= heap_size && heap_keys[best] < heap_keys[2 * pos])
            best = 2 * pos;
         if (2 * pos + 1 <= heap_size && heap_keys[best] < heap_keys[2 * pos + 1])
            best = 2 * pos + 1;
         if (best == pos)
            break;
         held            = heap_keys[best];
         heap_keys[best] = heap_keys[pos];
         heap_keys[pos]  = held;
         pos             = best;
      end
   endfunction

   // Apply one request to the mirror and return the view that follows it.
   function automatic heap_view_type apply_request(
         input logic [1:0] cmd,
         input logic signed [bhpq_pkg::KEY_W-1:0] key,
         input logic signed [bhpq_pkg::KEY_W-1:0] nkey);
      heap_view_type view;
      view.status = bhpq_pkg::STAT_OK;
      case (cmd)
         bhpq_pkg::CMD_INSERT: begin
            if (heap_size >= bhpq_pkg::HEAP_DEPTH) begin
               view.status = bhpq_pkg::STAT_FULL;
            end else begin
               heap_size++;
               heap_keys[heap_size] = key;
               sift_toward_root(heap_size);
            end
         end
         bhpq_pkg::CMD_REMOVE: begin
            if (heap_size == 0) begin
               view.status = bhpq_pkg::STAT_EMPTY;
            end else begin
               heap_keys[1] = heap_keys[heap_size];
               heap_size--;
               sift_toward_leaves(1);
            end
         end
         bhpq_pkg::CMD_INCREASE: begin
            // scan continues past each hit, even after the hit climbed
            if (nkey >= key) begin
               for (int i = 1; i <= heap_size; i++) begin
                  if (heap_keys[i] == key) begin
                     heap_keys[i] = nkey;
                     sift_toward_root(i);
                  end
               end
            end
         end
         default: ;
      endcase
      view.top_key     = (heap_size != 0) ? heap_keys[1] : '0;
      view.top_valid   = (heap_size != 0);
      view.entry_total = heap_size[bhpq_pkg::CNT_W-1:0];
      return view;
   endfunction

   task automatic report_mismatch(input string what, input logic [bhpq_pkg::KEY_W-1:0] got,
                                  input logic [bhpq_pkg::KEY_W-1:0] want);
      $display("%0t ns: response %s got %0h want %0h", $time, what, got, want);
      mismatch_count++;
   endtask

   task automatic check_response();
      heap_view_type want;
      if (expected_views.size() == 0) begin
         report_mismatch("with no request outstanding, top_key", rsp_top_key, '0);
         return;
      end
      want = expected_views.pop_front();
      if (rsp_top_key !== want.top_key)
         report_mismatch("top_key", rsp_top_key, want.top_key);
      if (rsp_top_valid !== want.top_valid)
         report_mismatch("top_valid", bhpq_pkg::KEY_W'(rsp_top_valid),
                         bhpq_pkg::KEY_W'(want.top_valid));
      if (rsp_entry_total !== want.entry_total)
         report_mismatch("entry_total", bhpq_pkg::KEY_W'(rsp_entry_total),
                         bhpq_pkg::KEY_W'(want.entry_total));
      if (rsp_status !== want.status)
         report_mismatch("status", bhpq_pkg::KEY_W'(rsp_status),
                         bhpq_pkg::KEY_W'(want.status));
   endtask

   // Watch both channels at each rising edge.
   always @(posedge clock) begin
      if (reset) begin
         heap_size = 0;
         expected_views.delete();
      end else begin
         if (rsp_strobe)
            check_response();
         if (start && !busy)
            expected_views.push_back(apply_request(req_cmd, req_key_value, req_new_key));
      end
      pending_count <= expected_views.size();
   end

endmodule

// ===== tb/sv/tb.sv =====
// Testbench top for the heap queue: clock, reset, request stimulus, watchdog and verdict.
`timescale 1ns / 100ps

module tb;

   localparam int          RANDOM_ITEMS   = 1680;
   localparam int          DRAIN_CYCLES   = 64;
   // limit covers the worst increase-key, on a full heap of equal keys
   localparam int          WATCHDOG_LIMIT = 6000;
   localparam logic [1:0]  CMD_UNUSED     = 2'd3;

   typedef enum {MIX_PHASE, FILL_PHASE, DRAIN_PHASE} phase_type;

   logic                              clock;
   logic                              reset;
   logic                              start;
   logic                              busy;
   logic [1:0]                        req_cmd;
   logic signed [bhpq_pkg::KEY_W-1:0] req_key_value;
   logic signed [bhpq_pkg::KEY_W-1:0] req_new_key;
   logic                              rsp_strobe;
   logic signed [bhpq_pkg::KEY_W-1:0] rsp_top_key;
   logic                              rsp_top_valid;
   logic [bhpq_pkg::CNT_W-1:0]        rsp_entry_total;
   logic [1:0]                        rsp_status;
   int                                mismatch_count;
   int                                pending_count;

   int                                idle_cycles;
   int                                burst_left;
   logic signed [bhpq_pkg::KEY_W-1:0] known_keys [$];

   binary_heap_max_priority_queue_top dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_cmd         (req_cmd),
      .req_key_value   (req_key_value),
      .req_new_key     (req_new_key),
      .rsp_strobe      (rsp_strobe),
      .rsp_top_key     (rsp_top_key),
      .rsp_top_valid   (rsp_top_valid),
      .rsp_entry_total (rsp_entry_total),
      .rsp_status      (rsp_status)
   );

   heap_queue_checker checker_inst (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_cmd         (req_cmd),
      .req_key_value   (req_key_value),
      .req_new_key     (req_new_key),
      .rsp_strobe      (rsp_strobe),
      .rsp_top_key     (rsp_top_key),
      .rsp_top_valid   (rsp_top_valid),
      .rsp_entry_total (rsp_entry_total),
      .rsp_status      (rsp_status),
      .mismatch_count  (mismatch_count),
      .pending_count   (pending_count)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // Watchdog: cycles with neither a request nor a response taken.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired after %0d idle cycles", idle_cycles);
         $display("Mismatches found");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Keys lean toward extremes and a narrow band so duplicates show up.
   function automatic logic signed [bhpq_pkg::KEY_W-1:0] pick_key();
      case ($urandom_range(0, 9))
         0:       return 32'sh7fff_ffff;
         1:       return 32'sh8000_0000;
         2, 3, 4: return $signed($urandom_range(0, 16)) - 8;
         default: return $urandom;
      endcase
   endfunction

   function automatic void remember_key(input logic signed [bhpq_pkg::KEY_W-1:0] key);
      known_keys.push_back(key);
      if (known_keys.size() > bhpq_pkg::HEAP_DEPTH)
         void'(known_keys.pop_front());
   endfunction

   // Hold one request until it is taken, then maybe pause.
   task automatic send_request(input logic [1:0] cmd,
                               input logic signed [bhpq_pkg::KEY_W-1:0] key,
                               input logic signed [bhpq_pkg::KEY_W-1:0] nkey);
      int gap;
      start         <= 1'b1;
      req_cmd       <= cmd;
      req_key_value <= key;
      req_new_key   <= nkey;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      if (cmd == bhpq_pkg::CMD_INSERT)
         remember_key(key);
      else if (cmd == bhpq_pkg::CMD_INCREASE)
         remember_key(nkey);
      // bursts of back-to-back requests with random gaps between them
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(1, 24);
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Corner cases on a fresh heap, then drain it past empty.
   task automatic run_directed();
      send_request(bhpq_pkg::CMD_REMOVE, 32'sd0, 32'sd0);       // remove on empty
      send_request(bhpq_pkg::CMD_INCREASE, 32'sd0, 32'sd1);     // increase on empty
      send_request(CMD_UNUSED, 32'sd0, 32'sd0);                 // unused code, empty
      send_request(bhpq_pkg::CMD_INSERT, 32'sh7fff_ffff, 32'sh8000_0000);
      send_request(bhpq_pkg::CMD_INSERT, 32'sh8000_0000, 32'sh7fff_ffff);
      send_request(bhpq_pkg::CMD_INSERT, 32'sd0, 32'sd0);
      send_request(bhpq_pkg::CMD_INSERT, -32'sd1, 32'sd0);
      send_request(bhpq_pkg::CMD_INSERT, 32'sd5, 32'sd0);
      send_request(bhpq_pkg::CMD_INSERT, 32'sd5, 32'sd0);
      send_request(bhpq_pkg::CMD_INSERT, 32'sd5, 32'sd0);
      send_request(bhpq_pkg::CMD_INCREASE, 32'sd5, 32'sd100);   // several matches
      send_request(bhpq_pkg::CMD_INCREASE, 32'sd100, 32'sd50);  // new below old
      send_request(bhpq_pkg::CMD_INCREASE, 32'sd12345, 32'sd20000); // no match
      send_request(bhpq_pkg::CMD_INCREASE, -32'sd1, -32'sd1);   // new equals old
      send_request(bhpq_pkg::CMD_INCREASE, 32'sh8000_0000, 32'sh7fff_ffff);
      send_request(CMD_UNUSED, -32'sd1, -32'sd1);               // unused code, all ones
      repeat (8)
         send_request(bhpq_pkg::CMD_REMOVE, $urandom, $urandom); // last one hits empty
   endtask

   // Phases that fill, drain or mix, so full and empty are both reached.
   task automatic run_random();
      phase_type                         mode;
      int                                phase_left;
      int                                roll;
      logic [1:0]                        cmd;
      logic signed [bhpq_pkg::KEY_W-1:0] key;
      logic signed [bhpq_pkg::KEY_W-1:0] nkey;
      phase_left = 0;
      mode       = MIX_PHASE;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (phase_left == 0) begin
            case ($urandom_range(0, 2))
               0:       mode = FILL_PHASE;
               1:       mode = DRAIN_PHASE;
               default: mode = MIX_PHASE;
            endcase
            phase_left = $urandom_range(40, 120);
         end
         phase_left--;
         roll = $urandom_range(0, 99);
         case (mode)
            FILL_PHASE:  cmd = (roll < 80) ? bhpq_pkg::CMD_INSERT :
                               (roll < 88) ? bhpq_pkg::CMD_INCREASE :
                               (roll < 97) ? bhpq_pkg::CMD_REMOVE : CMD_UNUSED;
            DRAIN_PHASE: cmd = (roll < 80) ? bhpq_pkg::CMD_REMOVE :
                               (roll < 88) ? bhpq_pkg::CMD_INSERT :
                               (roll < 97) ? bhpq_pkg::CMD_INCREASE : CMD_UNUSED;
            default:     cmd = (roll < 35) ? bhpq_pkg::CMD_INSERT :
                               (roll < 65) ? bhpq_pkg::CMD_REMOVE :
                               (roll < 95) ? bhpq_pkg::CMD_INCREASE : CMD_UNUSED;
         endcase
         key  = pick_key();
         nkey = $urandom;
         if (cmd == bhpq_pkg::CMD_INCREASE) begin
            // old key mostly one that was put in, so the scan finds it
            if (known_keys.size() != 0 && $urandom_range(0, 3) != 0)
               key = known_keys[$urandom_range(0, known_keys.size() - 1)];
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4, 5: nkey = key + $signed($urandom_range(0, 1000));
               6, 7:             nkey = pick_key();
               8:                nkey = key;
               default:          nkey = key - $signed($urandom_range(1, 50));
            endcase
         end
         send_request(cmd, key, nkey);
      end
   endtask

   initial begin
      reset         = 1'b1;
      start         = 1'b0;
      req_cmd       = bhpq_pkg::CMD_INSERT;
      req_key_value = '0;
      req_new_key   = '0;
      burst_left    = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      run_random();
      start <= 1'b0;
      do
         @(posedge clock);
      while (pending_count != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
